// File: design/bshd_pkg.sv
// ----------------------------------------------------------------------------
// bshd_pkg
// Shared constants, codes and types of the bit-serial Huffman decoder.
// ----------------------------------------------------------------------------
package bshd_pkg;

  localparam int ENTRIES       = 256;
  localparam int MAX_CODE_BITS = 63;

  localparam int CODE_W = 63;
  localparam int LEN_W  = 6;
  localparam int SYM_W  = 8;
  localparam int PEND_W = CODE_W + 1;
  localparam int PLEN_W = 8;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  localparam logic [PEND_W-1:0] CODE_LIMIT =
    {{(PEND_W - MAX_CODE_BITS){1'b0}}, {MAX_CODE_BITS{1'b1}}};

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_DATA  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_LEFTOVER = 2'd2
  } status_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  symbol;
  } entry_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [SYM_W-1:0] symbol;
  } scan_res_t;

endpackage

// File: design/bshd_table.sv
// ----------------------------------------------------------------------------
// bshd_table
// Code table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bshd_table (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [bshd_pkg::IDX_W-1:0] wr_addr_i,
  input  bshd_pkg::entry_t         wr_data_i,
  input  logic [bshd_pkg::IDX_W-1:0] rd_addr_i,
  output bshd_pkg::entry_t         rd_data_o
);
  import bshd_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/bshd_scan.sv
// ----------------------------------------------------------------------------
// bshd_scan
// Table search: walks the loaded entries one per cycle through the shared
// code and length comparator, stops at the first match.
// ----------------------------------------------------------------------------
module bshd_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bshd_pkg::CNT_W-1:0]  count_i,
  input  logic [bshd_pkg::PEND_W-1:0] key_code_i,
  input  logic [bshd_pkg::PLEN_W-1:0] key_len_i,
  output logic [bshd_pkg::IDX_W-1:0]  rd_addr_o,
  input  bshd_pkg::entry_t            rd_data_i,
  output bshd_pkg::scan_res_t         res_o
);
  import bshd_pkg::*;

  typedef enum logic {
    SC_IDLE,
    SC_RUN
  } scan_state_e;

  scan_state_e      state_q, state_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             pv_q, pv_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic             match;
  logic             issuing;

  // shared comparator
  assign match = pv_q
              && ({1'b0, rd_data_i.code} == key_code_i)
              && ({{(PLEN_W - LEN_W){1'b0}}, rd_data_i.len} == key_len_i);

  assign issuing   = issue_q < count_i;
  assign rd_addr_o = issue_q[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    res_o.done   = 1'b0;
    res_o.hit    = 1'b0;
    res_o.idx    = pidx_q;
    res_o.symbol = rd_data_i.symbol;
    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_RUN;
          issue_d = '0;
        end
      end
      SC_RUN: begin
        if (match) begin
          res_o.done = 1'b1;
          res_o.hit  = 1'b1;
          state_d    = SC_IDLE;
        end else if (!pv_q && !issuing) begin
          res_o.done = 1'b1;
          state_d    = SC_IDLE;
        end else begin
          pv_d   = issuing;
          pidx_d = issue_q[IDX_W-1:0];
          if (issuing) begin
            issue_d = issue_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      issue_q <= '0;
      pv_q    <= 1'b0;
      pidx_q  <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pv_q    <= pv_d;
      pidx_q  <= pidx_d;
    end
  end

endmodule

// File: design/bit_serial_huffman_decoder_core.sv
// ----------------------------------------------------------------------------
// bit_serial_huffman_decoder_core
// Bit-serial Huffman decoder: loads (symbol, length, code) entries and
// decodes coded bits one per transaction with a sequential table search.
//
//   channel   handshake            payload
//   request   start / busy         req_type_i, entry_symbol_i, entry_length_i,
//                                  entry_code_i, data_bit_i, last_bit_i
//   result    result_valid_o       has_symbol_o, out_symbol_o,
//                                  end_of_stream_o, status_o
//
// A clear, and a data bit while failed or on overflow, never raise busy. A
// load or a decoded data bit searches the table one entry per cycle through a
// single memory read port while busy. A result is shown for one cycle, the
// cycle after the search ends or after a data bit taken while failed or on
// overflow; the receiver cannot stall. Reset empties the table count and the
// pending code.
module bit_serial_huffman_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type_i,
  input  logic [bshd_pkg::SYM_W-1:0]  entry_symbol_i,
  input  logic [bshd_pkg::LEN_W-1:0]  entry_length_i,
  input  logic [bshd_pkg::CODE_W-1:0] entry_code_i,
  input  logic                        data_bit_i,
  input  logic                        last_bit_i,
  output logic                        result_valid_o,
  output logic                        has_symbol_o,
  output logic [bshd_pkg::SYM_W-1:0]  out_symbol_o,
  output logic                        end_of_stream_o,
  output logic [1:0]                  status_o
);
  import bshd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DATA
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [PLEN_W-1:0] plen_q, plen_d;
  logic              failed_q, failed_d;
  logic [1:0]        kind_q, kind_d;
  logic [PEND_W-1:0] key_code_q, key_code_d;
  logic [PLEN_W-1:0] key_len_q, key_len_d;
  logic [SYM_W-1:0]  load_sym_q, load_sym_d;
  logic              last_q, last_d;
  logic              rv_q, rv_d;
  logic              has_q, has_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic              eos_q, eos_d;
  logic [1:0]        status_q, status_d;

  logic              accept;
  logic              scan_start;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  scan_res_t         scan_res;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign wr_data = '{code:   key_code_q[CODE_W-1:0],
                     len:    key_len_q[LEN_W-1:0],
                     symbol: load_sym_q};

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pend_d     = pend_q;
    plen_d     = plen_q;
    failed_d   = failed_q;
    kind_d     = kind_q;
    key_code_d = key_code_q;
    key_len_d  = key_len_q;
    load_sym_d = load_sym_q;
    last_d     = last_q;
    rv_d       = 1'b0;
    has_d      = has_q;
    sym_d      = sym_q;
    eos_d      = eos_q;
    status_d   = status_q;
    scan_start = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count_q[IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_CLEAR: begin
              count_d  = '0;
              pend_d   = '0;
              plen_d   = '0;
              failed_d = 1'b0;
              kind_d   = STATUS_OK;
            end
            REQ_LOAD: begin
              key_code_d = {1'b0, entry_code_i};
              key_len_d  = {{(PLEN_W - LEN_W){1'b0}}, entry_length_i};
              load_sym_d = entry_symbol_i;
              scan_start = 1'b1;
              state_d    = ST_LOAD;
            end
            REQ_DATA: begin
              if (failed_q) begin
                rv_d     = 1'b1;
                has_d    = 1'b0;
                sym_d    = '0;
                eos_d    = last_bit_i;
                status_d = kind_q;
              end else if (pend_q >= CODE_LIMIT) begin
                failed_d = 1'b1;
                kind_d   = STATUS_OVERFLOW;
                rv_d     = 1'b1;
                has_d    = 1'b0;
                sym_d    = '0;
                eos_d    = last_bit_i;
                status_d = STATUS_OVERFLOW;
              end else begin
                key_code_d = {pend_q[PEND_W-2:0], data_bit_i};
                key_len_d  = plen_q + PLEN_W'(1);
                last_d     = last_bit_i;
                scan_start = 1'b1;
                state_d    = ST_DATA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (scan_res.done) begin
          state_d = ST_IDLE;
          if (scan_res.hit) begin
            wr_en   = 1'b1;
            wr_addr = scan_res.idx;
          end else if (count_q < CNT_W'(ENTRIES)) begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ST_DATA: begin
        if (scan_res.done) begin
          state_d  = ST_IDLE;
          has_d    = scan_res.hit;
          sym_d    = scan_res.hit ? scan_res.symbol : '0;
          eos_d    = last_q;
          status_d = STATUS_OK;
          rv_d     = scan_res.hit || last_q;
          if (scan_res.hit || last_q) begin
            pend_d = '0;
            plen_d = '0;
          end else begin
            pend_d = key_code_q;
            plen_d = key_len_q;
          end
          if (last_q && !scan_res.hit && (key_code_q != '0)) begin
            failed_d = 1'b1;
            kind_d   = STATUS_LEFTOVER;
            status_d = STATUS_LEFTOVER;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      pend_q   <= '0;
      plen_q   <= '0;
      failed_q <= 1'b0;
      kind_q   <= STATUS_OK;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      plen_q   <= plen_d;
      failed_q <= failed_d;
      kind_q   <= kind_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_code_q <= key_code_d;
    key_len_q  <= key_len_d;
    load_sym_q <= load_sym_d;
    last_q     <= last_d;
    has_q      <= has_d;
    sym_q      <= sym_d;
    eos_q      <= eos_d;
    status_q   <= status_d;
  end

  bshd_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bshd_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .count_i    (count_q),
    .key_code_i (key_code_q),
    .key_len_i  (key_len_q),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .res_o      (scan_res)
  );

  assign result_valid_o  = rv_q;
  assign has_symbol_o    = has_q;
  assign out_symbol_o    = sym_q;
  assign end_of_stream_o = eos_q;
  assign status_o        = status_q;

endmodule
